[rtl/core/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the heightmap generator checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PNF_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PNF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error(msg);

`endif

[rtl/core/pnf_pkg.sv]
// ----------------------------------------------------------------------------
// Heightmap generator package
// Widths, codes, beat types and the gradient function of the noise pipeline.
// ----------------------------------------------------------------------------
package pnf_pkg;

	localparam int PERM_ENTRIES = 256;
	localparam int PERM_AW      = 8;
	localparam int DIM_W        = 13;
	localparam int SCALE_W      = 16;
	localparam int PIX_W        = 12;
	localparam int CFG_W        = 16;
	localparam int CFG_IDX_W    = 2;
	localparam int PROD_W       = PIX_W + SCALE_W;
	localparam int DIVIDEND_W   = PROD_W + 8;
	localparam int DIV_STEPS    = DIVIDEND_W;
	localparam int COORD_W      = 24;
	localparam int FRAC_W       = 16;
	localparam int OCTAVES      = 4;
	localparam int POS_W        = FRAC_W + 2;
	localparam int GRAD_W       = FRAC_W + 3;
	localparam int LERP_W       = GRAD_W + 1;
	localparam int NOISE_W      = LERP_W + 1;
	localparam int FADE_W       = 2 * FRAC_W + 5;
	localparam int PW_W         = 20;
	localparam int U_W          = FRAC_W + 1;
	localparam int SAMPLE_W     = 18;
	localparam int ACC_W        = 23;
	localparam int BIASED_W     = 22;
	localparam int RECIP_W      = 23;
	localparam int QPROD_W      = BIASED_W + RECIP_W;
	localparam int RECIP_SHIFT  = 26;
	localparam int OUT_W        = 18;
	localparam int LANE_STAGES  = 6;
	localparam int LATENCY      = 1 + DIV_STEPS + LANE_STAGES + 2;

	localparam logic [FADE_W-1:0] FADE_TEN = FADE_W'(10) << (2 * FRAC_W);
	localparam logic signed [ACC_W-1:0] ACC_BIAS = ACC_W'(15 * 65536);
	localparam logic [RECIP_W-1:0] RECIP_15 = RECIP_W'(4473925);
	localparam logic [QPROD_W-RECIP_SHIFT-1:0] Q_BIAS = (QPROD_W-RECIP_SHIFT)'(65536);
	localparam logic signed [NOISE_W-1:0] HALF_Q16 = NOISE_W'(32768);

	typedef enum logic [0:0] {
		OP_LOAD = 1'b0,
		OP_EVAL = 1'b1
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MAP_WIDTH   = 2'd0,
		CFG_MAP_HEIGHT  = 2'd1,
		CFG_NOISE_SCALE = 2'd2
	} cfg_idx_t;

	typedef struct packed {
		logic               load;
		logic [PERM_AW-1:0] idx;
		logic [PERM_AW-1:0] val;
	} beat_t;

	typedef struct packed {
		logic [DIM_W-1:0]      rem_x;
		logic [DIVIDEND_W-1:0] work_x;
		logic [DIM_W-1:0]      rem_y;
		logic [DIVIDEND_W-1:0] work_y;
	} div_t;

	typedef struct packed {
		logic               en;
		logic [PERM_AW-1:0] addr;
	} init_wr_t;

	function automatic logic signed [GRAD_W-1:0] grad_q16(
		input logic [3:0]               h,
		input logic signed [POS_W-1:0]  x,
		input logic signed [POS_W-1:0]  y
	);
		logic signed [GRAD_W-1:0] a;
		logic signed [GRAD_W-1:0] b;
		a = (h < 4'd8) ? GRAD_W'(x) : GRAD_W'(y);
		if (h < 4'd4) begin
			b = GRAD_W'(y);
		end else if (h == 4'd12 || h == 4'd14) begin
			b = GRAD_W'(x);
		end else begin
			b = '0;
		end
		if (h[0]) begin
			a = -a;
		end
		if (h[1]) begin
			b = -b;
		end
		return a + b;
	endfunction

endpackage

[rtl/core/perlin_noise_2d_fractal.sv]
// Throughput: one beat per cycle while busy is low, loads and evaluates alike; a load
// gives no result. An evaluate beat reaches done through the input register, the
// 36-cell coordinate divider, the six-stage octave lanes, the sum and output registers.
// After reset, busy stays high while every table copy is set to identity.
// Results are strobed for one cycle on done; the receiver cannot stall.
// ----------------------------------------------------------------------------
// Fractal noise heightmap generator
// Pixel to coordinate divider chain, four parallel octave lanes and the
// weighted sum with its division by fifteen.
// ----------------------------------------------------------------------------
module perlin_noise_2d_fractal (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   start,
	output logic                                   busy,
	input  logic                                   opcode,
	input  logic [pnf_pkg::PERM_AW-1:0]            table_index,
	input  logic [pnf_pkg::PERM_AW-1:0]            table_value,
	input  logic [pnf_pkg::PIX_W-1:0]              pixel_x,
	input  logic [pnf_pkg::PIX_W-1:0]              pixel_y,
	input  logic                                   cfg_write,
	input  logic [pnf_pkg::CFG_IDX_W-1:0]          cfg_index,
	input  logic [pnf_pkg::CFG_W-1:0]              cfg_data,
	output logic                                   done,
	output logic signed [pnf_pkg::OUT_W-1:0]       height_value
);

	localparam int NS = pnf_pkg::DIV_STEPS;
	localparam int NO = pnf_pkg::OCTAVES;

	logic [pnf_pkg::DIM_W-1:0]   map_width_q, map_height_q, dx, dy;
	logic [pnf_pkg::SCALE_W-1:0] noise_scale_q;
	logic                        init_q;
	logic [pnf_pkg::PERM_AW-1:0] init_cnt_q;
	pnf_pkg::init_wr_t           init_wr;

	logic                        vld_s1;
	pnf_pkg::beat_t              beat_s1;
	logic [pnf_pkg::PROD_W-1:0]  prodx_s1, prody_s1;

	logic                        cvld [0:NS];
	pnf_pkg::beat_t              cbeat [0:NS];
	pnf_pkg::div_t               cdiv [0:NS];

	logic [pnf_pkg::COORD_W-1:0] nx, ny;
	logic signed [pnf_pkg::SAMPLE_W-1:0] smp [0:NO-1];
	logic signed [pnf_pkg::ACC_W-1:0]    acc_sum, acc_s7;
	logic [pnf_pkg::BIASED_W-1:0]        biased;
	logic [pnf_pkg::QPROD_W-1:0]         qprod;
	logic [pnf_pkg::QPROD_W-pnf_pkg::RECIP_SHIFT-1:0] quot;
	logic [pnf_pkg::LANE_STAGES+1:0]     ev_sr_q;
	logic signed [pnf_pkg::OUT_W-1:0]    height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_width_q   <= pnf_pkg::DIM_W'(256);
			map_height_q  <= pnf_pkg::DIM_W'(256);
			noise_scale_q <= pnf_pkg::SCALE_W'(256);
		end else if (cfg_write) begin
			unique case (cfg_index)
				pnf_pkg::CFG_MAP_WIDTH:   map_width_q   <= cfg_data[pnf_pkg::DIM_W-1:0];
				pnf_pkg::CFG_MAP_HEIGHT:  map_height_q  <= cfg_data[pnf_pkg::DIM_W-1:0];
				pnf_pkg::CFG_NOISE_SCALE: noise_scale_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_q     <= 1'b1;
			init_cnt_q <= '0;
		end else if (init_q) begin
			init_cnt_q <= init_cnt_q + 8'd1;
			if (init_cnt_q == 8'hFF) begin
				init_q <= 1'b0;
			end
		end
	end

	assign busy         = init_q;
	assign init_wr.en   = init_q;
	assign init_wr.addr = init_cnt_q;

	always_comb begin
		dx = (map_width_q == '0) ? pnf_pkg::DIM_W'(1) : map_width_q;
		dy = (map_height_q == '0) ? pnf_pkg::DIM_W'(1) : map_height_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= start & ~busy;
		end
	end

	always_ff @(posedge clk) begin
		beat_s1.load <= (opcode == pnf_pkg::OP_LOAD);
		beat_s1.idx  <= table_index;
		beat_s1.val  <= table_value;
		prodx_s1     <= pixel_x * noise_scale_q;
		prody_s1     <= pixel_y * noise_scale_q;
	end

	always_comb begin
		cvld[0]         = vld_s1;
		cbeat[0]        = beat_s1;
		cdiv[0].rem_x   = '0;
		cdiv[0].rem_y   = '0;
		cdiv[0].work_x  = {prodx_s1, 8'h00};
		cdiv[0].work_y  = {prody_s1, 8'h00};
	end

	for (genvar k = 0; k < NS; k++) begin : g_div
		pnf_div_cell u_cell (
			.clk(clk), .arst_n(arst_n),
			.vld_in(cvld[k]), .beat_in(cbeat[k]), .div_in(cdiv[k]),
			.dx(dx), .dy(dy),
			.vld_s1(cvld[k+1]), .beat_s1(cbeat[k+1]), .div_s1(cdiv[k+1])
		);
	end

	assign nx = cdiv[NS].work_x[pnf_pkg::COORD_W-1:0];
	assign ny = cdiv[NS].work_y[pnf_pkg::COORD_W-1:0];

	for (genvar i = 0; i < NO; i++) begin : g_oct
		pnf_octave_lane u_lane (
			.clk(clk), .arst_n(arst_n),
			.vld_in(cvld[NS]), .beat_in(cbeat[NS]),
			.cx(nx << i), .cy(ny << i),
			.init_wr(init_wr),
			.sample(smp[i])
		);
	end

	always_comb begin
		acc_sum = '0;
		for (int i = 0; i < NO; i++) begin
			acc_sum = acc_sum + (pnf_pkg::ACC_W'(smp[i]) <<< (NO - 1 - i));
		end
		biased = pnf_pkg::BIASED_W'(acc_s7 + pnf_pkg::ACC_BIAS);
		qprod  = pnf_pkg::QPROD_W'(biased) * pnf_pkg::QPROD_W'(pnf_pkg::RECIP_15);
		quot   = qprod[pnf_pkg::QPROD_W-1:pnf_pkg::RECIP_SHIFT];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ev_sr_q <= '0;
		end else begin
			ev_sr_q <= {ev_sr_q[pnf_pkg::LANE_STAGES:0], cvld[NS] & ~cbeat[NS].load};
		end
	end

	always_ff @(posedge clk) begin
		acc_s7   <= acc_sum;
		height_q <= pnf_pkg::OUT_W'(quot - pnf_pkg::Q_BIAS);
	end

	assign done         = ev_sr_q[pnf_pkg::LANE_STAGES+1];
	assign height_value = height_q;

endmodule

[rtl/core/pnf_perm_ram.sv]
// ----------------------------------------------------------------------------
// Permutation table copy
// One write port and two registered read ports over the 256-entry table.
// ----------------------------------------------------------------------------
module pnf_perm_ram (
	input  logic                         clk,
	input  logic                         we,
	input  logic [pnf_pkg::PERM_AW-1:0]  waddr,
	input  logic [pnf_pkg::PERM_AW-1:0]  wdata,
	input  logic [pnf_pkg::PERM_AW-1:0]  raddr0,
	input  logic [pnf_pkg::PERM_AW-1:0]  raddr1,
	output logic [pnf_pkg::PERM_AW-1:0]  rdata0,
	output logic [pnf_pkg::PERM_AW-1:0]  rdata1
);

	logic [pnf_pkg::PERM_AW-1:0] mem [0:pnf_pkg::PERM_ENTRIES-1];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata0 <= mem[raddr0];
		rdata1 <= mem[raddr1];
	end

endmodule

[rtl/core/pnf_div_cell.sv]
// ----------------------------------------------------------------------------
// Coordinate divider cell
// One restoring division step for both pixel coordinates, plus the beat.
// ----------------------------------------------------------------------------
module pnf_div_cell (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        vld_in,
	input  pnf_pkg::beat_t              beat_in,
	input  pnf_pkg::div_t               div_in,
	input  logic [pnf_pkg::DIM_W-1:0]   dx,
	input  logic [pnf_pkg::DIM_W-1:0]   dy,
	output logic                        vld_s1,
	output pnf_pkg::beat_t              beat_s1,
	output pnf_pkg::div_t               div_s1
);

	logic [pnf_pkg::DIM_W:0] trial_x;
	logic [pnf_pkg::DIM_W:0] trial_y;
	logic                    ge_x;
	logic                    ge_y;

	always_comb begin
		trial_x = {div_in.rem_x, div_in.work_x[pnf_pkg::DIVIDEND_W-1]};
		trial_y = {div_in.rem_y, div_in.work_y[pnf_pkg::DIVIDEND_W-1]};
		ge_x    = trial_x >= {1'b0, dx};
		ge_y    = trial_y >= {1'b0, dy};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		beat_s1 <= beat_in;
		div_s1.rem_x  <= ge_x ? pnf_pkg::DIM_W'(trial_x - {1'b0, dx})
		                      : pnf_pkg::DIM_W'(trial_x);
		div_s1.rem_y  <= ge_y ? pnf_pkg::DIM_W'(trial_y - {1'b0, dy})
		                      : pnf_pkg::DIM_W'(trial_y);
		div_s1.work_x <= {div_in.work_x[pnf_pkg::DIVIDEND_W-2:0], ge_x};
		div_s1.work_y <= {div_in.work_y[pnf_pkg::DIVIDEND_W-2:0], ge_y};
	end

endmodule

[rtl/core/pnf_octave_lane.sv]
// ----------------------------------------------------------------------------
// Octave lane
// Six-stage noise evaluation for one octave: hash chain, fade, gradients, lerps.
// ----------------------------------------------------------------------------
module pnf_octave_lane (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   vld_in,
	input  pnf_pkg::beat_t                         beat_in,
	input  logic [pnf_pkg::COORD_W-1:0]            cx,
	input  logic [pnf_pkg::COORD_W-1:0]            cy,
	input  pnf_pkg::init_wr_t                      init_wr,
	output logic signed [pnf_pkg::SAMPLE_W-1:0]    sample
);

	localparam int AW = pnf_pkg::PERM_AW;
	localparam int FW = pnf_pkg::FRAC_W;

	logic          ld_s1, ld_s2;
	pnf_pkg::beat_t beat_s1, beat_s2;

	logic [AW-1:0] yi_s1;
	logic [FW-1:0] fx_s1, fy_s1, fx_s2, fy_s2, fx_s3, fy_s3;
	logic [2*FW-1:0] ffx_s1, ffy_s1;
	logic [FW-1:0] t3x_s2, t3y_s2;
	logic [pnf_pkg::PW_W-1:0] px_s2, py_s2;
	logic [pnf_pkg::U_W-1:0] u_s3, v_s3, u_s4, v_s4, v_s5;

	logic [AW-1:0] p0, p1, aa, ab, ba, bb, h_aa, h_ab, h_ba, h_bb;
	logic [AW-1:0] a_idx, b_idx;
	logic [2*FW-1:0] t3x_full, t3y_full;
	logic [pnf_pkg::FADE_W-1:0] pxs, pys;
	logic [FW+pnf_pkg::PW_W-1:0] ux_full, vy_full;

	logic signed [pnf_pkg::POS_W-1:0] x0, x1, y0, y1;
	logic signed [pnf_pkg::GRAD_W-1:0] gaa_s4, gba_s4, gab_s4, gbb_s4;
	logic signed [pnf_pkg::LERP_W-1:0] dlo, dhi, lo, hi, lo_s5, hi_s5;
	logic signed [pnf_pkg::LERP_W+pnf_pkg::U_W:0] mlo, mhi;
	logic signed [pnf_pkg::NOISE_W-1:0] dn, n, n_s6;
	logic signed [pnf_pkg::NOISE_W+pnf_pkg::U_W:0] mn;

	logic          we_a, we_b, we_d;
	logic [AW-1:0] wa_a, wd_a, wa_b, wd_b, wa_d, wd_d;

	always_comb begin
		we_a = init_wr.en | (vld_in & beat_in.load);
		wa_a = init_wr.en ? init_wr.addr : beat_in.idx;
		wd_a = init_wr.en ? init_wr.addr : beat_in.val;
		we_b = init_wr.en | ld_s1;
		wa_b = init_wr.en ? init_wr.addr : beat_s1.idx;
		wd_b = init_wr.en ? init_wr.addr : beat_s1.val;
		we_d = init_wr.en | ld_s2;
		wa_d = init_wr.en ? init_wr.addr : beat_s2.idx;
		wd_d = init_wr.en ? init_wr.addr : beat_s2.val;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ld_s1 <= 1'b0;
			ld_s2 <= 1'b0;
		end else begin
			ld_s1 <= vld_in & beat_in.load;
			ld_s2 <= ld_s1;
		end
	end

	pnf_perm_ram u_ram_a (
		.clk(clk), .we(we_a), .waddr(wa_a), .wdata(wd_a),
		.raddr0(cx[pnf_pkg::COORD_W-1:FW]), .raddr1(cx[pnf_pkg::COORD_W-1:FW] + 8'd1),
		.rdata0(p0), .rdata1(p1)
	);

	always_comb begin
		a_idx    = p0 + yi_s1;
		b_idx    = p1 + yi_s1;
		t3x_full = ffx_s1[2*FW-1:FW] * fx_s1;
		t3y_full = ffy_s1[2*FW-1:FW] * fy_s1;
		pxs = pnf_pkg::FADE_TEN + pnf_pkg::FADE_W'(ffx_s1) * pnf_pkg::FADE_W'(6)
		    - ((pnf_pkg::FADE_W'(fx_s1) * pnf_pkg::FADE_W'(15)) << FW);
		pys = pnf_pkg::FADE_TEN + pnf_pkg::FADE_W'(ffy_s1) * pnf_pkg::FADE_W'(6)
		    - ((pnf_pkg::FADE_W'(fy_s1) * pnf_pkg::FADE_W'(15)) << FW);
	end

	pnf_perm_ram u_ram_b (
		.clk(clk), .we(we_b), .waddr(wa_b), .wdata(wd_b),
		.raddr0(a_idx), .raddr1(a_idx + 8'd1), .rdata0(aa), .rdata1(ab)
	);

	pnf_perm_ram u_ram_c (
		.clk(clk), .we(we_b), .waddr(wa_b), .wdata(wd_b),
		.raddr0(b_idx), .raddr1(b_idx + 8'd1), .rdata0(ba), .rdata1(bb)
	);

	pnf_perm_ram u_ram_d (
		.clk(clk), .we(we_d), .waddr(wa_d), .wdata(wd_d),
		.raddr0(aa), .raddr1(ab), .rdata0(h_aa), .rdata1(h_ab)
	);

	pnf_perm_ram u_ram_e (
		.clk(clk), .we(we_d), .waddr(wa_d), .wdata(wd_d),
		.raddr0(ba), .raddr1(bb), .rdata0(h_ba), .rdata1(h_bb)
	);

	always_comb begin
		ux_full = t3x_s2 * px_s2;
		vy_full = t3y_s2 * py_s2;
		x0 = {2'b00, fx_s3};
		x1 = {2'b11, fx_s3};
		y0 = {2'b00, fy_s3};
		y1 = {2'b11, fy_s3};
		dlo = pnf_pkg::LERP_W'(gba_s4) - pnf_pkg::LERP_W'(gaa_s4);
		dhi = pnf_pkg::LERP_W'(gbb_s4) - pnf_pkg::LERP_W'(gab_s4);
		mlo = $signed({1'b0, u_s4}) * dlo;
		mhi = $signed({1'b0, u_s4}) * dhi;
		lo  = pnf_pkg::LERP_W'(gaa_s4) + pnf_pkg::LERP_W'(mlo >>> FW);
		hi  = pnf_pkg::LERP_W'(gab_s4) + pnf_pkg::LERP_W'(mhi >>> FW);
		dn  = pnf_pkg::NOISE_W'(hi_s5) - pnf_pkg::NOISE_W'(lo_s5);
		mn  = $signed({1'b0, v_s5}) * dn;
		n   = pnf_pkg::NOISE_W'(lo_s5) + pnf_pkg::NOISE_W'(mn >>> FW);
	end

	always_ff @(posedge clk) begin
		beat_s1 <= beat_in;
		beat_s2 <= beat_s1;
		yi_s1   <= cy[pnf_pkg::COORD_W-1:FW];
		fx_s1   <= cx[FW-1:0];
		fy_s1   <= cy[FW-1:0];
		ffx_s1  <= cx[FW-1:0] * cx[FW-1:0];
		ffy_s1  <= cy[FW-1:0] * cy[FW-1:0];
		fx_s2   <= fx_s1;
		fy_s2   <= fy_s1;
		t3x_s2  <= t3x_full[2*FW-1:FW];
		t3y_s2  <= t3y_full[2*FW-1:FW];
		px_s2   <= pxs[FW+pnf_pkg::PW_W-1:FW];
		py_s2   <= pys[FW+pnf_pkg::PW_W-1:FW];
		fx_s3   <= fx_s2;
		fy_s3   <= fy_s2;
		u_s3    <= ux_full[FW+pnf_pkg::U_W-1:FW];
		v_s3    <= vy_full[FW+pnf_pkg::U_W-1:FW];
		gaa_s4  <= pnf_pkg::grad_q16(h_aa[3:0], x0, y0);
		gba_s4  <= pnf_pkg::grad_q16(h_ba[3:0], x1, y0);
		gab_s4  <= pnf_pkg::grad_q16(h_ab[3:0], x0, y1);
		gbb_s4  <= pnf_pkg::grad_q16(h_bb[3:0], x1, y1);
		u_s4    <= u_s3;
		v_s4    <= v_s3;
		lo_s5   <= lo;
		hi_s5   <= hi;
		v_s5    <= v_s4;
		n_s6    <= n;
	end

	assign sample = pnf_pkg::SAMPLE_W'((n_s6 >>> 1) + pnf_pkg::HALF_Q16);

endmodule

[rtl/core/pnf_checker.sv]
// ----------------------------------------------------------------------------
// Heightmap generator checker
// Port-level timing checks on start, busy and done, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pnf_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic opcode,
	input logic done
);

	logic eval_acc;

	assign eval_acc = start && !busy && (opcode == pnf_pkg::OP_EVAL);

	`PNF_ASSERT_NEXT(a_busy_stays_low, clk, arst_n, !busy, !busy, "busy rose after init")
	`PNF_ASSERT_SAME(a_no_done_in_init, clk, arst_n, busy, !done, "done during init")
	`PNF_ASSERT_SAME(a_done_has_eval, clk, arst_n, done, $past(eval_acc, pnf_pkg::LATENCY), "done without evaluate beat")
	`PNF_ASSERT_SAME(a_eval_gives_done, clk, arst_n, $past(eval_acc, pnf_pkg::LATENCY), done, "evaluate beat lost")

endmodule

bind perlin_noise_2d_fractal pnf_checker u_pnf_checker (
	.clk(clk),
	.arst_n(arst_n),
	.start(start),
	.busy(busy),
	.opcode(opcode),
	.done(done)
);
